[hdl/hsvrgb_pkg.sv]
// Shared constants and types for the HSV to RGB converter.
package hsvrgb_pkg;

    localparam int HUE_W          = 15;
    localparam int POS_W          = 13;
    localparam int WEIGHT_W       = 12;
    localparam int CHAN_W         = 8;
    localparam int DIVISOR        = 15;
    localparam int DIV_SHIFT      = 8;

    localparam logic [HUE_W-1:0] SECTOR_UNITS    = 15'd3840;
    localparam logic [HUE_W-1:0] TWO_SECTORS     = 15'd7680;
    localparam logic [HUE_W-1:0] THREE_SECTORS   = 15'd11520;
    localparam logic [HUE_W-1:0] FOUR_SECTORS    = 15'd15360;
    localparam logic [HUE_W-1:0] FIVE_SECTORS    = 15'd19200;
    localparam logic [HUE_W-1:0] FULL_TURN_UNITS = 15'd23040;

    typedef enum logic {
        ACT_HSV   = 1'b0,
        ACT_RATIO = 1'b1
    } t_action;

    typedef enum logic [2:0] {
        SEC_RED_YELLOW   = 3'd0,
        SEC_YELLOW_GREEN = 3'd1,
        SEC_GREEN_CYAN   = 3'd2,
        SEC_CYAN_BLUE    = 3'd3,
        SEC_BLUE_MAGENTA = 3'd4,
        SEC_MAGENTA_RED  = 3'd5,
        SEC_NONE         = 3'd6
    } t_sector;

endpackage

[hdl/hsv_to_rgb_converter_top.sv]
// HSV to RGB converter: eight-stage pipeline, one colour per clock.
// A request is taken whenever start is high; busy never rises.
// The result strobe o_valid is the last bit of the valid shift register and marks the output registers.
// The chroma, second-component and divide-by-fifteen multipliers each have registered outputs.
// Synchronous active-low reset clears the valid pipeline only; requests in flight are dropped.
module hsv_to_rgb_converter_top #(
    parameter int FRAC_BITS = 15
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_action,
    input  logic [hsvrgb_pkg::HUE_W-1:0]  i_hue_degrees,
    input  logic [FRAC_BITS:0]            i_saturation_level,
    input  logic [FRAC_BITS:0]            i_brightness_level,
    input  logic [FRAC_BITS:0]            i_turn_fraction,
    output logic                          o_valid,
    output logic [7:0]                    o_red_out,
    output logic [7:0]                    o_green_out,
    output logic [7:0]                    o_blue_out
);
    import hsvrgb_pkg::*;

    localparam int FW      = FRAC_BITS + 1;
    localparam int CW      = 2 * FRAC_BITS + 1;
    localparam int QW      = 2 * FRAC_BITS + 4;
    localparam int PW      = CW + WEIGHT_W;
    localparam int RW      = FW + HUE_W;
    localparam int LATENCY = 8;
    localparam int DIV_LAT = 3;
    localparam logic [FW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    function automatic logic [CHAN_W-1:0] scale_channel(input logic [CW-1:0] acc);
        logic [CW+7:0] wide;
        wide = {acc, 8'b0} - (CW+8)'(acc);
        // The sum never exceeds one, so the scaled value never exceeds full scale.
        return wide[2*FRAC_BITS +: CHAN_W];
    endfunction

    logic [LATENCY-1:0] r_vld;

    logic [HUE_W-1:0]   r1_hue;
    logic [FW-1:0]      r1_sat;
    logic [FW-1:0]      r1_val;

    logic [CW-1:0]      r2_c;
    logic [FW-1:0]      r2_val;
    t_sector            r2_sec;
    logic [WEIGHT_W-1:0] r2_w;

    logic [QW-1:0]      r3_q;
    logic [CW-1:0]      r3_c;
    logic [CW-1:0]      r3_m;
    t_sector            r3_sec;

    logic [CW-1:0]      r_c_dly   [DIV_LAT];
    logic [CW-1:0]      r_m_dly   [DIV_LAT];
    t_sector            r_sec_dly [DIV_LAT];

    logic [CW-1:0]      r7_acc_r;
    logic [CW-1:0]      r7_acc_g;
    logic [CW-1:0]      r7_acc_b;

    logic [CHAN_W-1:0]  r_red;
    logic [CHAN_W-1:0]  r_green;
    logic [CHAN_W-1:0]  r_blue;

    logic               n_take;
    logic [FW-1:0]      n_sat;
    logic [FW-1:0]      n_val;
    logic [FW-1:0]      n_frac;
    logic [RW-1:0]      n_ratio_prod;
    logic [2*FW-1:0]    n_c_full;
    t_sector            n_sec;
    logic [POS_W-1:0]   n_pos;
    logic [WEIGHT_W-1:0] n_w;
    logic [PW-1:0]      n_x_prod;
    logic [CW-1:0]      n_m;
    logic [QW-4:0]      n_x;
    logic [CW-1:0]      n_x_c;
    logic [CW-1:0]      n_comp_r;
    logic [CW-1:0]      n_comp_g;
    logic [CW-1:0]      n_comp_b;

    assign busy   = 1'b0;
    assign n_take = start && !busy;

    // Stage 1: clamp and map a turn fraction onto the hue circle.
    always_comb begin
        n_sat        = (i_saturation_level > ONE) ? ONE : i_saturation_level;
        n_val        = (i_brightness_level > ONE) ? ONE : i_brightness_level;
        n_frac       = (i_turn_fraction > ONE) ? ONE : i_turn_fraction;
        n_ratio_prod = RW'(n_frac) * RW'(FULL_TURN_UNITS);
    end

    // Stage 2: chroma, sector and the weight of the second component.
    always_comb begin
        n_c_full = (2*FW)'(r1_val) * (2*FW)'(r1_sat);
        n_sec    = SEC_NONE;
        n_pos    = '0;
        if (r1_hue < SECTOR_UNITS) begin
            n_sec = SEC_RED_YELLOW;
            n_pos = POS_W'(r1_hue);
        end else if (r1_hue < TWO_SECTORS) begin
            n_sec = SEC_YELLOW_GREEN;
            n_pos = POS_W'(r1_hue);
        end else if (r1_hue < THREE_SECTORS) begin
            n_sec = SEC_GREEN_CYAN;
            n_pos = POS_W'(r1_hue - TWO_SECTORS);
        end else if (r1_hue < FOUR_SECTORS) begin
            n_sec = SEC_CYAN_BLUE;
            n_pos = POS_W'(r1_hue - TWO_SECTORS);
        end else if (r1_hue < FIVE_SECTORS) begin
            n_sec = SEC_BLUE_MAGENTA;
            n_pos = POS_W'(r1_hue - FOUR_SECTORS);
        end else if (r1_hue < FULL_TURN_UNITS) begin
            n_sec = SEC_MAGENTA_RED;
            n_pos = POS_W'(r1_hue - FOUR_SECTORS);
        end
        // The weight is one sector minus the distance from the sector boundary.
        if (n_pos >= POS_W'(SECTOR_UNITS)) begin
            n_w = WEIGHT_W'(POS_W'(TWO_SECTORS) - n_pos);
        end else begin
            n_w = WEIGHT_W'(n_pos);
        end
    end

    // Stage 3: scaled second component and the common offset.
    always_comb begin
        n_x_prod = PW'(r2_c) * PW'(r2_w);
        n_m      = {r2_val, {FRAC_BITS{1'b0}}} - r2_c;
    end

    hsvrgb_div15 #(
        .QW (QW)
    ) u_div15 (
        .i_clk  (i_clk),
        .i_num  (r3_q),
        .o_quot (n_x)
    );

    // Stage 7: place chroma and second component by sector, then add the offset.
    always_comb begin
        n_x_c    = CW'(n_x);
        n_comp_r = '0;
        n_comp_g = '0;
        n_comp_b = '0;
        case (r_sec_dly[DIV_LAT-1])
            SEC_RED_YELLOW: begin
                n_comp_r = r_c_dly[DIV_LAT-1];
                n_comp_g = n_x_c;
            end
            SEC_YELLOW_GREEN: begin
                n_comp_r = n_x_c;
                n_comp_g = r_c_dly[DIV_LAT-1];
            end
            SEC_GREEN_CYAN: begin
                n_comp_g = r_c_dly[DIV_LAT-1];
                n_comp_b = n_x_c;
            end
            SEC_CYAN_BLUE: begin
                n_comp_g = n_x_c;
                n_comp_b = r_c_dly[DIV_LAT-1];
            end
            SEC_BLUE_MAGENTA: begin
                n_comp_r = n_x_c;
                n_comp_b = r_c_dly[DIV_LAT-1];
            end
            SEC_MAGENTA_RED: begin
                n_comp_r = r_c_dly[DIV_LAT-1];
                n_comp_b = n_x_c;
            end
            default: begin
                n_comp_r = '0;
                n_comp_g = '0;
                n_comp_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LATENCY-2:0], n_take};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_action == ACT_RATIO) begin
            r1_hue <= n_ratio_prod[FRAC_BITS +: HUE_W];
            r1_sat <= ONE;
            r1_val <= ONE;
        end else begin
            r1_hue <= i_hue_degrees;
            r1_sat <= n_sat;
            r1_val <= n_val;
        end

        r2_c   <= n_c_full[CW-1:0];
        r2_val <= r1_val;
        r2_sec <= n_sec;
        r2_w   <= n_w;

        r3_q   <= n_x_prod[DIV_SHIFT +: QW];
        r3_c   <= r2_c;
        r3_m   <= n_m;
        r3_sec <= r2_sec;

        r_c_dly[0]   <= r3_c;
        r_m_dly[0]   <= r3_m;
        r_sec_dly[0] <= r3_sec;
        for (int i = 1; i < DIV_LAT; i++) begin
            r_c_dly[i]   <= r_c_dly[i-1];
            r_m_dly[i]   <= r_m_dly[i-1];
            r_sec_dly[i] <= r_sec_dly[i-1];
        end

        r7_acc_r <= n_comp_r + r_m_dly[DIV_LAT-1];
        r7_acc_g <= n_comp_g + r_m_dly[DIV_LAT-1];
        r7_acc_b <= n_comp_b + r_m_dly[DIV_LAT-1];

        r_red   <= scale_channel(r7_acc_r);
        r_green <= scale_channel(r7_acc_g);
        r_blue  <= scale_channel(r7_acc_b);
    end

    assign o_valid     = r_vld[LATENCY-1];
    assign o_red_out   = r_red;
    assign o_green_out = r_green;
    assign o_blue_out  = r_blue;

endmodule

[hdl/hsvrgb_div15.sv]
// Three-stage pipelined divider by fifteen using a split reciprocal multiply.
module hsvrgb_div15 #(
    parameter int QW = 34
) (
    input  logic          i_clk,
    input  logic [QW-1:0] i_num,
    output logic [QW-4:0] o_quot
);
    import hsvrgb_pkg::*;

    localparam int KW = QW - 3;
    localparam int LW = QW / 2;
    localparam int HW = QW - LW;
    localparam int SW = 2 * QW - 2;
    localparam int EW = QW - 2;
    localparam logic [QW:0]   ONE_SH = {1'b1, {QW{1'b0}}};
    localparam logic [KW-1:0] KVAL   = KW'(ONE_SH / DIVISOR);

    logic [HW+KW-1:0] r_prod_hi;
    logic [LW+KW-1:0] r_prod_lo;
    logic [QW-1:0]    r_num_a;
    logic [EW-1:0]    r_est;
    logic [QW-1:0]    r_num_b;
    logic [QW-4:0]    r_quot;

    logic [SW-1:0]    n_sum;
    logic [QW-1:0]    n_est_ext;
    logic [QW-1:0]    n_est_x15;
    logic [QW-1:0]    n_rem_full;
    logic [EW-1:0]    n_quot_full;

    // The estimate undershoots the true quotient by at most one.
    always_comb begin
        n_sum       = (SW'(r_prod_hi) << LW) + SW'(r_prod_lo);
        n_est_ext   = QW'(r_est);
        n_est_x15   = (n_est_ext << 4) - n_est_ext;
        n_rem_full  = r_num_b - n_est_x15;
        n_quot_full = r_est + EW'(n_rem_full[4:0] >= 5'(DIVISOR));
    end

    always_ff @(posedge i_clk) begin
        r_prod_hi <= HW'(i_num[QW-1:LW]) * KVAL;
        r_prod_lo <= LW'(i_num[LW-1:0]) * KVAL;
        r_num_a   <= i_num;
        r_est     <= n_sum[SW-1:QW];
        r_num_b   <= r_num_a;
        r_quot    <= n_quot_full[QW-4:0];
    end

    assign o_quot = r_quot;

endmodule
